// File: sv/tppbd_pkg.sv
`timescale 1ns / 1ps

package tppbd_pkg;

  localparam int PULSE_BITS = 8;
  localparam int DATA_BITS  = 8;
  localparam int SLOT_W     = $clog2(DATA_BITS + 1);
  localparam int SLOT_IDX_W = $clog2(DATA_BITS);
  localparam int CMP_W      = PULSE_BITS + 2;

  localparam int IDEAL_W = 8;
  localparam int TOL_W   = 7;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_SHORT  = 2'd0,
    REG_MEDIUM = 2'd1,
    REG_LONG   = 2'd2,
    REG_TOL    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_SHORT  = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_LONG   = 2'd2,
    CLS_NONE   = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    PAIR_ZERO = 3'd0,
    PAIR_ONE  = 3'd1,
    PAIR_NEW  = 3'd2,
    PAIR_END  = 3'd3,
    PAIR_BAD  = 3'd4
  } pair_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_UNREADABLE = 3'd1,
    STAT_CHECK      = 3'd2,
    STAT_PAUSE      = 3'd3,
    STAT_END        = 3'd4
  } status_t;

  typedef struct packed {
    logic [IDEAL_W-1:0] short_ideal;
    logic [IDEAL_W-1:0] medium_ideal;
    logic [IDEAL_W-1:0] long_ideal;
    logic [TOL_W-1:0]   tolerance;
  } cfg_t;

  // one classified pulse as it sits in the queue
  typedef struct packed {
    logic pause;
    cls_t cls;
  } q_word_t;

endpackage

// File: sv/tppbd_front.sv
`timescale 1ns / 1ps

module tppbd_front import tppbd_pkg::*; (
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PULSE_BITS-1:0] pulse_width,
  input  logic                  q_full,
  output logic                  push,
  output q_word_t               push_word
);

  logic [CMP_W-1:0] p, s, m, l, t;
  logic [2:0]       hits;
  cls_t             cls;

  assign p = CMP_W'(pulse_width);
  assign s = CMP_W'(cfg.short_ideal);
  assign m = CMP_W'(cfg.medium_ideal);
  assign l = CMP_W'(cfg.long_ideal);
  assign t = CMP_W'(cfg.tolerance);

  // ideal - tol < p < ideal + tol, rearranged to stay unsigned
  assign hits[0] = (p + t > s) && (p < s + t);
  assign hits[1] = (p + t > m) && (p < m + t);
  assign hits[2] = (p + t > l) && (p < l + t);

  always_comb begin
    case (hits)
      3'b001:  cls = CLS_SHORT;
      3'b010:  cls = CLS_MEDIUM;
      3'b100:  cls = CLS_LONG;
      // overlap: nearer ideal wins, tie goes to the upper class
      3'b011:  cls = ((p << 1) < (s + m)) ? CLS_SHORT : CLS_MEDIUM;
      3'b110:  cls = ((p << 1) < (m + l)) ? CLS_MEDIUM : CLS_LONG;
      default: cls = CLS_NONE;
    endcase
  end

  assign in_ready        = !q_full && !rst;
  assign push            = in_valid && in_ready;
  assign push_word.pause = (pulse_width == '0);
  assign push_word.cls   = cls;

endmodule

// File: sv/tppbd_queue.sv
`timescale 1ns / 1ps

module tppbd_queue import tppbd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    pop,
  input  q_word_t wr_word,
  output logic    full,
  output logic    valid,
  output q_word_t rd_word
);

  q_word_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]   count, count_next;
  logic                 do_push, do_pop;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_word = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

endmodule

// File: sv/tppbd_back.sv
`timescale 1ns / 1ps

module tppbd_back import tppbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  q_word_t              q_word,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_BITS-1:0] byte_value,
  output logic [2:0]           status
);

  typedef enum logic [1:0] {
    ST_HUNT = 2'b01,
    ST_BYTE = 2'b10
  } state_t;

  state_t               state, state_next;
  cls_t                 held_cls, held_cls_next;
  logic                 held_valid, held_valid_next;
  logic [SLOT_W-1:0]    bit_slot, bit_slot_next;
  logic [DATA_BITS-1:0] shift_byte, shift_byte_next;
  logic                 parity_acc, parity_acc_next;
  logic                 emit;
  status_t              emit_status;
  logic [DATA_BITS-1:0] emit_value;
  pair_t                code;

  function automatic pair_t pair_of(cls_t first, cls_t second);
    pair_t r;
    r = PAIR_BAD;
    if (first == CLS_SHORT && second == CLS_MEDIUM) r = PAIR_ZERO;
    if (first == CLS_MEDIUM && second == CLS_SHORT) r = PAIR_ONE;
    if (first == CLS_LONG && second == CLS_MEDIUM)  r = PAIR_NEW;
    if (first == CLS_LONG && second == CLS_SHORT)   r = PAIR_END;
    return r;
  endfunction

  assign pop  = q_valid && (!out_valid || out_ready);
  assign code = pair_of(held_cls, q_word.cls);

  always_comb begin
    state_next      = state;
    held_cls_next   = held_cls;
    held_valid_next = held_valid;
    bit_slot_next   = bit_slot;
    shift_byte_next = shift_byte;
    parity_acc_next = parity_acc;
    emit            = 1'b0;
    emit_status     = STAT_OK;
    emit_value      = '0;
    if (pop) begin
      if (q_word.pause) begin
        held_cls_next   = CLS_NONE;
        held_valid_next = 1'b0;
        if (state == ST_BYTE) begin
          emit        = 1'b1;
          emit_status = STAT_PAUSE;
        end
      end else if (!held_valid) begin
        held_cls_next   = q_word.cls;
        held_valid_next = 1'b1;
      end else if (state == ST_HUNT) begin
        case (code)
          PAIR_NEW: begin
            held_cls_next   = CLS_NONE;
            held_valid_next = 1'b0;
            state_next      = ST_BYTE;
          end
          PAIR_END: begin
            held_cls_next   = CLS_NONE;
            held_valid_next = 1'b0;
            emit            = 1'b1;
            emit_status     = STAT_END;
          end
          // slide one pulse along
          default: held_cls_next = q_word.cls;
        endcase
      end else begin
        held_cls_next   = CLS_NONE;
        held_valid_next = 1'b0;
        if (bit_slot < SLOT_W'(DATA_BITS)) begin
          if (code == PAIR_ZERO || code == PAIR_ONE) begin
            shift_byte_next[bit_slot[SLOT_IDX_W-1:0]] = (code == PAIR_ONE);
            parity_acc_next = parity_acc ^ (code == PAIR_ONE);
            bit_slot_next   = bit_slot + 1'b1;
          end else begin
            emit        = 1'b1;
            emit_status = STAT_UNREADABLE;
          end
        end else begin
          emit = 1'b1;
          if (code == PAIR_BAD) begin
            emit_status = STAT_UNREADABLE;
          end else if ((code == PAIR_ONE && parity_acc) ||
                       (code == PAIR_ZERO && !parity_acc)) begin
            emit_status = STAT_OK;
            emit_value  = shift_byte;
          end else begin
            emit_status = STAT_CHECK;
          end
        end
      end
      // any result ends the byte
      if (emit || state_next == ST_BYTE && state == ST_HUNT) begin
        bit_slot_next   = '0;
        shift_byte_next = '0;
        parity_acc_next = 1'b1;
      end
      if (emit) begin
        state_next = ST_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_HUNT;
      held_cls   <= CLS_NONE;
      held_valid <= 1'b0;
      bit_slot   <= '0;
      shift_byte <= '0;
      parity_acc <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held_cls   <= held_cls_next;
      held_valid <= held_valid_next;
      bit_slot   <= bit_slot_next;
      shift_byte <= shift_byte_next;
      parity_acc <= parity_acc_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_value <= emit_value;
      status     <= emit_status;
    end
  end

`ifndef ASSERT_OFF
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    bit_slot <= SLOT_W'(DATA_BITS))
    else $error("bit slot past check pair");

  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HUNT) |-> (bit_slot == '0 && shift_byte == '0 && parity_acc))
    else $error("byte state left over while hunting");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_OK) |-> (byte_value == '0))
    else $error("error word carries data");

  a_emit_from_pop: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(pop))
    else $error("result without a queue word");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop)
    else $error("queue popped while output stalled");
`endif

endmodule

// File: sv/tape_pulse_pair_byte_decoder.sv
`timescale 1ns / 1ps
// channel   dir  handshake                      payload
// pulse in  in   in_valid / in_ready            pulse_width
// result    out  out_valid / out_ready          byte_value, status
// config    in   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One pulse word per cycle sustained while the queue is not full; a result's
// pulse is classified into the queue, then a sequencer step moves it to the out
// reg. The 2-entry queue between classifier and sequencer sets in_ready: it
// drops only in reset or while full, i.e. while out_ready holds the result word.
// Reset (rst, synchronous) empties the queue, returns to hunting with no pulse
// held and loads the default ideal widths and tolerance.

module tape_pulse_pair_byte_decoder import tppbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PULSE_BITS-1:0] pulse_width,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_BITS-1:0]  byte_value,
  output logic [2:0]            status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     push, q_full, q_valid, pop;
  q_word_t  push_word, rd_word;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_ideal  <= IDEAL_W'(48);
      cfg.medium_ideal <= IDEAL_W'(66);
      cfg.long_ideal   <= IDEAL_W'(86);
      cfg.tolerance    <= TOL_W'(10);
    end else if (wr_en) begin
      case (reg_idx)
        REG_SHORT:  cfg.short_ideal  <= pwdata[IDEAL_W-1:0];
        REG_MEDIUM: cfg.medium_ideal <= pwdata[IDEAL_W-1:0];
        REG_LONG:   cfg.long_ideal   <= pwdata[IDEAL_W-1:0];
        REG_TOL:    cfg.tolerance    <= pwdata[TOL_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SHORT:  prdata = APB_DW'(cfg.short_ideal);
      REG_MEDIUM: prdata = APB_DW'(cfg.medium_ideal);
      REG_LONG:   prdata = APB_DW'(cfg.long_ideal);
      REG_TOL:    prdata = APB_DW'(cfg.tolerance);
      default:    prdata = '0;
    endcase
  end

  tppbd_front u_front (
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pulse_width(pulse_width),
    .q_full     (q_full),
    .push       (push),
    .push_word  (push_word)
  );

  tppbd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .wr_word(push_word),
    .full   (q_full),
    .valid  (q_valid),
    .rd_word(rd_word)
  );

  tppbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (rd_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte_value(byte_value),
    .status    (status)
  );

endmodule

// File: dv/tape_pulse_pair_byte_decoder_tb.sv
`timescale 1ns / 1ps

module tape_pulse_pair_byte_decoder_tb;
  import tppbd_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PULSE_BITS-1:0] pulse_width;
  logic                  out_valid;
  logic                  out_ready;
  logic [DATA_BITS-1:0]  byte_value;
  logic [2:0]            status;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  tape_pulse_pair_byte_decoder uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pulse_width(pulse_width),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_value(byte_value), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  typedef struct {
    logic [DATA_BITS-1:0] value;
    status_t              st;
  } byte_result_t;

  typedef struct {
    logic [PULSE_BITS-1:0] w;
    bit                    typed;
    bit                    has;
    status_t               st;
  } pulse_row_t;

  // directed pulses at reset widths; typed rows carry their known outcome
  localparam int DIR_N = 22;
  pulse_row_t dir_rows [DIR_N] = '{
    '{8'd0,   1'b1, 1'b0, STAT_OK},          // pause while hunting
    '{8'd255, 1'b0, 1'b0, STAT_OK},
    '{8'd86,  1'b0, 1'b0, STAT_OK},
    '{8'd48,  1'b1, 1'b1, STAT_END},         // long-short while hunting
    '{8'd86,  1'b0, 1'b0, STAT_OK},
    '{8'd66,  1'b0, 1'b0, STAT_OK},
    '{8'd0,   1'b1, 1'b1, STAT_PAUSE},       // pause inside byte
    '{8'd86,  1'b0, 1'b0, STAT_OK},
    '{8'd66,  1'b0, 1'b0, STAT_OK},
    '{8'd86,  1'b0, 1'b0, STAT_OK},
    '{8'd66,  1'b1, 1'b1, STAT_UNREADABLE},  // marker in a bit slot
    '{8'd86,  1'b0, 1'b0, STAT_OK},
    '{8'd66,  1'b0, 1'b0, STAT_OK},
    '{8'd1,   1'b0, 1'b0, STAT_OK},
    '{8'd48,  1'b1, 1'b1, STAT_UNREADABLE},  // unclassified pulse in slot
    '{8'd48,  1'b0, 1'b0, STAT_OK},
    '{8'd57,  1'b0, 1'b0, STAT_OK},          // short/medium tie goes medium
    '{8'd76,  1'b0, 1'b0, STAT_OK},
    '{8'd128, 1'b0, 1'b0, STAT_OK},
    '{8'd254, 1'b0, 1'b0, STAT_OK},
    '{8'd86,  1'b0, 1'b0, STAT_OK},
    '{8'd48,  1'b1, 1'b1, STAT_END}
  };

  localparam int PHASES = 7;
  cfg_t phase_cfg [PHASES] = '{
    '{8'd48,  8'd66,  8'd86,  7'd10},
    '{8'd0,   8'd128, 8'd255, 7'd127},
    '{8'd20,  8'd21,  8'd22,  7'd1},
    '{8'd100, 8'd110, 8'd120, 7'd20},
    '{8'd255, 8'd255, 8'd255, 7'd0},
    '{8'd48,  8'd66,  8'd86,  7'd10},       // replaced by random widths
    '{8'd48,  8'd66,  8'd86,  7'd10}
  };
  int phase_items [PHASES] = '{300, 300, 250, 300, 60, 250, 190};

  // decoder model state, updated at the sampling edge
  logic [IDEAL_W-1:0]   cfg_short = 8'd48;
  logic [IDEAL_W-1:0]   cfg_medium = 8'd66;
  logic [IDEAL_W-1:0]   cfg_long = 8'd86;
  logic [TOL_W-1:0]     cfg_tol = 7'd10;
  cls_t                 held_cls = CLS_NONE;
  bit                   held_ok = 1'b0;
  bit                   frame_open = 1'b0;
  int                   bit_idx = 0;
  logic [DATA_BITS-1:0] shift_acc = '0;
  logic                 parity_run = 1'b1;

  byte_result_t pending_bytes [$];
  int           errors = 0;

  // stimulus side
  cfg_t                  gen_cfg = '{8'd48, 8'd66, 8'd86, 7'd10};
  int                    burst_left = 0;
  int                    sent_count = 0;
  bit                    row_typed;
  bit                    row_has;
  status_t               row_st;
  logic                  hold_req;

  function automatic cls_t pulse_class(input logic [PULSE_BITS-1:0] w);
    int p, s, m, l, t;
    bit hs, hm, hl;
    p = w;
    s = cfg_short;
    m = cfg_medium;
    l = cfg_long;
    t = cfg_tol;
    hs = (p > s - t) && (p < s + t);
    hm = (p > m - t) && (p < m + t);
    hl = (p > l - t) && (p < l + t);
    case ({hl, hm, hs})
      3'b001: return CLS_SHORT;
      3'b010: return CLS_MEDIUM;
      3'b100: return CLS_LONG;
      3'b011: return ((p - s) < (m - p)) ? CLS_SHORT : CLS_MEDIUM;
      3'b110: return ((p - m) < (l - p)) ? CLS_MEDIUM : CLS_LONG;
      default: return CLS_NONE;
    endcase
  endfunction

  function automatic pair_t pair_of(input cls_t a, input cls_t b);
    if (a == CLS_SHORT && b == CLS_MEDIUM) return PAIR_ZERO;
    if (a == CLS_MEDIUM && b == CLS_SHORT) return PAIR_ONE;
    if (a == CLS_LONG && b == CLS_MEDIUM) return PAIR_NEW;
    if (a == CLS_LONG && b == CLS_SHORT) return PAIR_END;
    return PAIR_BAD;
  endfunction

  function automatic void back_to_hunt();
    held_cls = CLS_NONE;
    held_ok = 1'b0;
    frame_open = 1'b0;
    bit_idx = 0;
    shift_acc = '0;
    parity_run = 1'b1;
  endfunction

  // advance the decoder model by one pulse; returns 1 when a byte word results
  function automatic bit decode_step(input logic [PULSE_BITS-1:0] w,
                                     output logic [DATA_BITS-1:0] val,
                                     output status_t st);
    cls_t c;
    pair_t pc;
    logic [DATA_BITS-1:0] done_byte;
    logic want;
    val = '0;
    st = STAT_OK;
    if (w == '0) begin
      if (frame_open) begin
        back_to_hunt();
        st = STAT_PAUSE;
        return 1'b1;
      end
      held_cls = CLS_NONE;
      held_ok = 1'b0;
      return 1'b0;
    end
    c = pulse_class(w);
    if (!held_ok) begin
      held_cls = c;
      held_ok = 1'b1;
      return 1'b0;
    end
    pc = pair_of(held_cls, c);
    if (!frame_open) begin
      if (pc == PAIR_NEW) begin
        back_to_hunt();
        frame_open = 1'b1;
        return 1'b0;
      end
      if (pc == PAIR_END) begin
        held_cls = CLS_NONE;
        held_ok = 1'b0;
        st = STAT_END;
        return 1'b1;
      end
      held_cls = c;
      return 1'b0;
    end
    held_cls = CLS_NONE;
    held_ok = 1'b0;
    if (bit_idx < DATA_BITS) begin
      if (pc == PAIR_ZERO || pc == PAIR_ONE) begin
        shift_acc[bit_idx] = (pc == PAIR_ONE);
        parity_run = parity_run ^ (pc == PAIR_ONE);
        bit_idx++;
        return 1'b0;
      end
      back_to_hunt();
      st = STAT_UNREADABLE;
      return 1'b1;
    end
    done_byte = shift_acc;
    want = parity_run;
    back_to_hunt();
    if (pc == PAIR_BAD) begin
      st = STAT_UNREADABLE;
    end else if ((pc == PAIR_ONE && want) || (pc == PAIR_ZERO && !want)) begin
      val = done_byte;
      st = STAT_OK;
    end else begin
      st = STAT_CHECK;
    end
    return 1'b1;
  endfunction

  // sampling edge: register writes, accepted pulses, result words
  logic [DATA_BITS-1:0] pred_val;
  status_t              pred_st;
  byte_result_t         want_word;

  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_SHORT:  cfg_short = pwdata[IDEAL_W-1:0];
          REG_MEDIUM: cfg_medium = pwdata[IDEAL_W-1:0];
          REG_LONG:   cfg_long = pwdata[IDEAL_W-1:0];
          REG_TOL:    cfg_tol = pwdata[TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (decode_step(pulse_width, pred_val, pred_st) && !row_typed)
          pending_bytes.push_back('{pred_val, pred_st});
        if (row_typed && row_has)
          pending_bytes.push_back('{'0, row_st});
      end
      if (out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          errors++;
          $error("unexpected result word: byte_value 0x%02h status %0d", byte_value, status);
        end else begin
          want_word = pending_bytes.pop_front();
          if (byte_value !== want_word.value) begin
            errors++;
            $error("byte_value: expected 0x%02h, got 0x%02h", want_word.value, byte_value);
          end
          if (status !== want_word.st) begin
            errors++;
            $error("status: expected %0d, got %0d", want_word.st, status);
          end
        end
      end
    end
  end

  task automatic send_pulse(input logic [PULSE_BITS-1:0] w, input bit typed = 1'b0,
                            input bit has = 1'b0, input status_t st = STAT_OK);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pulse_width <= w;
    row_typed <= typed;
    row_has <= has;
    row_st <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // a pulse aimed inside the window of the given class
  function automatic logic [PULSE_BITS-1:0] width_for(input cls_t c);
    int ideal, t, v;
    case (c)
      CLS_SHORT:  ideal = gen_cfg.short_ideal;
      CLS_MEDIUM: ideal = gen_cfg.medium_ideal;
      default:    ideal = gen_cfg.long_ideal;
    endcase
    t = gen_cfg.tolerance;
    v = ideal;
    if (t > 1) v = ideal + $urandom_range(0, 2 * t - 2) - (t - 1);
    if (v < 1) v = 1;
    if (v > 255) v = 255;
    return PULSE_BITS'(v);
  endfunction

  // lead-in, eight bit pairs and a check pair, now and then damaged
  task automatic send_frame();
    logic [DATA_BITS-1:0] data;
    logic par;
    int kind, pos, k;
    logic [PULSE_BITS-1:0] seq [$];
    data = DATA_BITS'($urandom_range(0, 255));
    par = ~^data;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) seq.push_back(width_for(cls_t'($urandom_range(0, 2))));
    seq.push_back(width_for(CLS_LONG));
    seq.push_back(width_for(CLS_MEDIUM));
    pos = seq.size();
    for (k = 0; k < DATA_BITS; k++) begin
      seq.push_back(width_for(data[k] ? CLS_MEDIUM : CLS_SHORT));
      seq.push_back(width_for(data[k] ? CLS_SHORT : CLS_MEDIUM));
    end
    if (kind < 12) par = ~par;
    if (kind >= 12 && kind < 18) begin
      seq.push_back(width_for(CLS_LONG));
      seq.push_back(width_for(kind[0] ? CLS_SHORT : CLS_MEDIUM));
    end else begin
      seq.push_back(width_for(par ? CLS_MEDIUM : CLS_SHORT));
      seq.push_back(width_for(par ? CLS_SHORT : CLS_MEDIUM));
    end
    if (kind >= 18 && kind < 24) begin
      seq[$urandom_range(pos, seq.size() - 1)] = '0;
    end else if (kind >= 24 && kind < 30) begin
      seq[$urandom_range(pos, seq.size() - 1)] = PULSE_BITS'($urandom_range(1, 255));
    end else if (kind >= 30 && kind < 34) begin
      k = pos + 2 * $urandom_range(0, DATA_BITS - 1);
      seq[k] = width_for(CLS_LONG);
      seq[k + 1] = width_for(CLS_SHORT);
    end
    foreach (seq[i]) send_pulse(seq[i]);
  endtask

  // stop offering, wait out every expected word plus the pipeline tail
  task automatic drain_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [APB_DW-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(int'(r) * 4);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // receiver: segments of differing readiness, one long hold-off on request
  initial begin : result_sink
    int seg, mode, k;
    bit held_once;
    held_once = 1'b0;
    out_ready <= 1'b0;
    forever begin
      if (hold_req && !held_once) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        held_once = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(10, 100);
      for (k = 0; k < seg; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((k % 5) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int ph, pick, stop_at;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pulse_width <= '0;
    row_typed <= 1'b0;
    row_has <= 1'b0;
    row_st <= STAT_OK;
    hold_req <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_pulse(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].has, dir_rows[i].st);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_quiet();
        gen_cfg = phase_cfg[ph];
        if (ph == 5) begin
          gen_cfg.short_ideal = IDEAL_W'($urandom_range(0, 255));
          gen_cfg.medium_ideal = IDEAL_W'($urandom_range(0, 255));
          gen_cfg.long_ideal = IDEAL_W'($urandom_range(0, 255));
          gen_cfg.tolerance = TOL_W'($urandom_range(1, 40));
        end
        cfg_write(REG_SHORT, APB_DW'(gen_cfg.short_ideal));
        cfg_write(REG_MEDIUM, APB_DW'(gen_cfg.medium_ideal));
        cfg_write(REG_LONG, APB_DW'(gen_cfg.long_ideal));
        cfg_write(REG_TOL, APB_DW'(gen_cfg.tolerance));
        if (ph == 3) hold_req <= 1'b1;
      end
      stop_at = sent_count + phase_items[ph];
      while (sent_count < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_frame();
        end else if (pick < 80) begin
          send_pulse(width_for(CLS_LONG));
          send_pulse(width_for(CLS_SHORT));
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 6))
            send_pulse(($urandom_range(0, 6) == 0) ? '0 : PULSE_BITS'($urandom_range(1, 255)));
        end else begin
          repeat ($urandom_range(1, 4)) send_pulse(width_for(cls_t'($urandom_range(0, 2))));
        end
      end
    end

    drain_quiet();
    if (pending_bytes.size() != 0) begin
      errors++;
      $error("%0d expected byte words never arrived", pending_bytes.size());
    end
    if (errors == 0) begin
      $display("tape_pulse_pair_byte_decoder_tb: done, clean");
    end else begin
      $display("tape_pulse_pair_byte_decoder_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tape_pulse_pair_byte_decoder_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
sv/tppbd_pkg.sv
sv/tppbd_front.sv
sv/tppbd_queue.sv
sv/tppbd_back.sv
sv/tape_pulse_pair_byte_decoder.sv
dv/tape_pulse_pair_byte_decoder_tb.sv
